>>> src/tara_pkg.sv
// Package for the texture atlas rectangle allocator.
// Holds field widths, status and register codes, and the controller/datapath structs.
// Depends on nothing.
`default_nettype none
package tara_pkg;

	localparam int FIELD_W  = 13;
	localparam int LAYER_W  = 3;
	localparam int STATUS_W = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_ROOM   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_LAYER = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_PAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAGE_HEIGHT = 2'd1;

	localparam logic [FIELD_W-1:0] PAGE_DIM_RESET = 13'd1024;

	typedef struct packed {
		logic       accept;
		logic       prep;
		logic       open_page;
		logic       page_init;
		logic       note_free;
		logic       rd;
		logic       scan;
		logic       load_reg;
		logic       origin;
		logic [1:0] corner;
		logic       take_cand;
		logic       eval;
		logic       commit;
		logic       load_out;
	} cmd_t;

	typedef struct packed {
		logic is_erase;
		logic layer_bad;
		logic size_ok;
		logic page_open;
		logic lacks_area;
		logic last_page;
		logic can_open;
		logic slot_valid;
		logic cand_ok;
		logic commit_ok;
	} sts_t;

endpackage
`default_nettype wire

>>> src/tara_req_if.sv
// Request channel: one beat is an insert or erase command.
// Depends on tara_pkg.
`default_nettype none
interface tara_req_if;
	import tara_pkg::*;
	logic               valid;
	logic               ready;
	logic               op;
	logic [FIELD_W-1:0] rect_width;
	logic [FIELD_W-1:0] rect_height;
	logic [LAYER_W-1:0] erase_layer;
	logic [FIELD_W-1:0] erase_x;
	logic [FIELD_W-1:0] erase_y;
	modport source (output valid, op, rect_width, rect_height, erase_layer, erase_x, erase_y,
		input ready);
	modport sink (input valid, op, rect_width, rect_height, erase_layer, erase_x, erase_y,
		output ready);
endinterface
`default_nettype wire

>>> src/tara_rsp_if.sv
// Response channel: one beat per request with status and placement.
// Depends on tara_pkg.
`default_nettype none
interface tara_rsp_if;
	import tara_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [LAYER_W-1:0]  placed_layer;
	logic [FIELD_W-1:0]  placed_x;
	logic [FIELD_W-1:0]  placed_y;
	modport source (output valid, status, placed_layer, placed_x, placed_y, input ready);
	modport sink (input valid, status, placed_layer, placed_x, placed_y, output ready);
endinterface
`default_nettype wire

>>> src/tara_cfg_if.sv
// Configuration write channel: register index and write data per beat.
// Depends on tara_pkg.
`default_nettype none
interface tara_cfg_if;
	import tara_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [FIELD_W-1:0]   data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> src/tara_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none
module tara_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                             clk,
	input  wire                             we,
	input  wire [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  wire [WIDTH-1:0]                 wdata,
	input  wire                             re,
	input  wire [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

>>> src/tara_ctrl.sv
// Controller: sequences page, candidate and overlap scans for the allocator.
// Depends on tara_pkg; drives the datapath through cmd_t, reads sts_t.
`default_nettype none
module tara_ctrl #(
	parameter int MAX_PAGES        = 8,
	parameter int REGIONS_PER_PAGE = 16
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  req_valid,
	output logic                                 req_ready,
	input  wire                                  rsp_ready,
	output logic                                 rsp_valid,
	input  tara_pkg::sts_t                       sts,
	output tara_pkg::cmd_t                       cmd,
	output logic [$clog2(MAX_PAGES+1)-1:0]       page,
	output logic [((REGIONS_PER_PAGE > 1) ? $clog2(REGIONS_PER_PAGE) : 1)-1:0] slot
);
	import tara_pkg::*;

	localparam int PCW = $clog2(MAX_PAGES + 1);
	localparam int SB  = (REGIONS_PER_PAGE > 1) ? $clog2(REGIONS_PER_PAGE) : 1;
	localparam logic [SB-1:0] SLOT_LAST = SB'(REGIONS_PER_PAGE - 1);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_PREP   = 4'd1;
	localparam logic [3:0] S_PAGE   = 4'd2;
	localparam logic [3:0] S_CAND   = 4'd3;
	localparam logic [3:0] S_CWAIT  = 4'd4;
	localparam logic [3:0] S_CORNER = 4'd5;
	localparam logic [3:0] S_SCAN   = 4'd6;
	localparam logic [3:0] S_DRAIN  = 4'd7;
	localparam logic [3:0] S_EVAL   = 4'd8;
	localparam logic [3:0] S_COMMIT = 4'd9;
	localparam logic [3:0] S_FIN    = 4'd10;

	logic [3:0]     state_q, state_d;
	logic [PCW-1:0] page_q, page_d;
	logic [SB-1:0]  c_q, c_d;
	logic [SB-1:0]  s_q, s_d;
	logic [1:0]     k_q, k_d;
	logic           orig_q, orig_d;
	logic           out_valid_q, out_valid_d;
	logic           adv;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;
	assign page      = page_q;
	assign slot      = (state_q == S_SCAN) ? s_q : c_q;

	always_comb begin
		state_d     = state_q;
		page_d      = page_q;
		c_d         = c_q;
		s_d         = s_q;
		k_d         = k_q;
		orig_d      = orig_q;
		out_valid_d = out_valid_q;
		adv         = 1'b0;
		cmd         = '0;
		cmd.origin  = orig_q;
		cmd.corner  = k_q;
		if (out_valid_q && rsp_ready) begin
			out_valid_d = 1'b0;
		end
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				if (sts.is_erase) begin
					s_d     = '0;
					state_d = sts.layer_bad ? S_FIN : S_SCAN;
				end else if (sts.size_ok) begin
					page_d  = '0;
					state_d = S_PAGE;
				end else begin
					state_d = S_FIN;
				end
			end
			S_PAGE: begin
				if (!sts.page_open) begin
					state_d = S_FIN;
				end else if (sts.lacks_area && !sts.last_page) begin
					page_d = page_q + PCW'(1);
				end else begin
					// room on this page, or last page short of area: open one more if below MAX_PAGES, still try this one
					cmd.open_page = sts.lacks_area && sts.can_open;
					cmd.page_init = 1'b1;
					orig_d        = 1'b1;
					c_d           = '0;
					state_d       = S_CAND;
				end
			end
			S_CAND: begin
				if (orig_q) begin
					k_d     = '0;
					state_d = S_CORNER;
				end else begin
					cmd.note_free = 1'b1;
					if (sts.slot_valid) begin
						cmd.rd  = 1'b1;
						state_d = S_CWAIT;
					end else if (c_q == SLOT_LAST) begin
						state_d = S_COMMIT;
					end else begin
						c_d = c_q + SB'(1);
					end
				end
			end
			S_CWAIT: begin
				cmd.load_reg = 1'b1;
				k_d          = '0;
				state_d      = S_CORNER;
			end
			S_CORNER: begin
				if (sts.cand_ok) begin
					cmd.take_cand = 1'b1;
					s_d           = '0;
					state_d       = S_SCAN;
				end else begin
					adv = 1'b1;
				end
			end
			S_SCAN: begin
				cmd.rd   = 1'b1;
				cmd.scan = 1'b1;
				if (s_q == SLOT_LAST) begin
					state_d = S_DRAIN;
				end else begin
					s_d = s_q + SB'(1);
				end
			end
			S_DRAIN: begin
				state_d = sts.is_erase ? S_FIN : S_EVAL;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				adv      = 1'b1;
			end
			S_COMMIT: begin
				if (sts.commit_ok) begin
					cmd.commit = 1'b1;
					state_d    = S_FIN;
				end else begin
					page_d  = page_q + PCW'(1);
					state_d = S_PAGE;
				end
			end
			S_FIN: begin
				if (!out_valid_q || rsp_ready) begin
					cmd.load_out = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		// step to next corner, then next region
		if (adv) begin
			if (orig_q || k_q == 2'd3) begin
				orig_d = 1'b0;
				if (orig_q) begin
					state_d = S_CAND;
				end else if (c_q == SLOT_LAST) begin
					state_d = S_COMMIT;
				end else begin
					c_d     = c_q + SB'(1);
					state_d = S_CAND;
				end
			end else begin
				k_d     = k_q + 2'd1;
				state_d = S_CORNER;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			page_q      <= '0;
			c_q         <= '0;
			s_q         <= '0;
			k_q         <= '0;
			orig_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			page_q      <= page_d;
			c_q         <= c_d;
			s_q         <= s_d;
			k_q         <= k_d;
			orig_q      <= orig_d;
			out_valid_q <= out_valid_d;
		end
	end
endmodule
`default_nettype wire

>>> src/tara_dp.sv
// Datapath: page state, region valid bits, geometry RAM, candidate and overlap math.
// Depends on tara_pkg, tara_cfg_if and tara_ram; commanded by tara_ctrl.
`default_nettype none
module tara_dp #(
	parameter int MAX_PAGES        = 8,
	parameter int REGIONS_PER_PAGE = 16,
	parameter int COORD_BITS       = 13
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	tara_cfg_if.sink                              cfg,
	input  tara_pkg::cmd_t                        cmd,
	output tara_pkg::sts_t                        sts,
	input  wire [$clog2(MAX_PAGES+1)-1:0]         page,
	input  wire [((REGIONS_PER_PAGE > 1) ? $clog2(REGIONS_PER_PAGE) : 1)-1:0] slot,
	input  wire                                   op,
	input  wire [tara_pkg::FIELD_W-1:0]           rect_width,
	input  wire [tara_pkg::FIELD_W-1:0]           rect_height,
	input  wire [tara_pkg::LAYER_W-1:0]           erase_layer,
	input  wire [tara_pkg::FIELD_W-1:0]           erase_x,
	input  wire [tara_pkg::FIELD_W-1:0]           erase_y,
	output logic [tara_pkg::STATUS_W-1:0]         status,
	output logic [tara_pkg::LAYER_W-1:0]          placed_layer,
	output logic [tara_pkg::FIELD_W-1:0]          placed_x,
	output logic [tara_pkg::FIELD_W-1:0]          placed_y
);
	import tara_pkg::*;

	localparam int CB  = COORD_BITS;
	localparam int SW  = ((CB > FIELD_W) ? CB : FIELD_W) + 1;
	localparam int AW  = 2 * CB;
	localparam int PCW = $clog2(MAX_PAGES + 1);
	localparam int PB  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int SB  = (REGIONS_PER_PAGE > 1) ? $clog2(REGIONS_PER_PAGE) : 1;
	localparam int D   = MAX_PAGES * REGIONS_PER_PAGE;
	localparam int AB  = $clog2(D > 1 ? D : 2);
	localparam int GW  = 4 * CB;
	localparam int LW  = (PCW > LAYER_W) ? PCW : LAYER_W;
	localparam logic [SW-1:0] LIMIT = SW'(1) << (CB - 1);

	// latched request
	logic               op_q;
	logic [FIELD_W-1:0] w_q, h_q, ex_q, ey_q;
	logic [LAYER_W-1:0] layer_q;

	logic [FIELD_W-1:0] pw_cfg_q, ph_cfg_q;
	logic [AW-1:0]      area_q, total_q;
	logic [PCW-1:0]     open_q;
	logic [AW-1:0]      used_q [MAX_PAGES];
	logic               valid_q [D];

	logic [CB-1:0]      rx_q, ry_q, rw_q, rh_q;
	logic [CB-1:0]      cand_x_q, cand_y_q, best_x_q, best_y_q;
	logic               found_q, free_found_q, hit_q, chk_s1;
	logic [SB-1:0]      free_slot_q, slot_s1;
	logic [STATUS_W-1:0] status_q;

	logic [SW-1:0] w_sw, h_sw, pw_raw, ph_raw, pw, ph;
	logic [CB-1:0] wc, hc, pwc, phc;
	logic [LW-1:0] layer_x;
	logic [PB-1:0] layer_pg, pg;
	logic          layer_bad;
	logic [AW-1:0] used_cur, free_a, used_sub;
	logic [AB-1:0] ram_addr, vidx_s1, commit_addr;
	logic [SW-1:0] rx_sw, ry_sw, cx, cy, bx_sw, by_sw;
	logic          better_blocked;
	logic [GW-1:0] rd_data, wr_data;
	logic [SW-1:0] gx, gy, gw, gh, x0, y0, x1, y1;
	logic          overlap, match, vs1;

	assign cfg.ready = 1'b1;

	always_comb begin
		w_sw   = SW'(w_q);
		h_sw   = SW'(h_q);
		pw_raw = SW'(pw_cfg_q);
		ph_raw = SW'(ph_cfg_q);
		pw     = (pw_raw > LIMIT) ? LIMIT : pw_raw;
		ph     = (ph_raw > LIMIT) ? LIMIT : ph_raw;
		wc     = w_sw[CB-1:0];
		hc     = h_sw[CB-1:0];
		pwc    = pw[CB-1:0];
		phc    = ph[CB-1:0];

		layer_x   = LW'(layer_q);
		layer_pg  = layer_x[PB-1:0];
		layer_bad = layer_x >= LW'(open_q);
		pg        = op_q ? layer_pg : page[PB-1:0];

		used_cur = (int'(pg) < MAX_PAGES) ? used_q[pg] : '0;
		free_a   = (used_cur > total_q) ? '0 : (total_q - used_cur);
		used_sub = (used_cur > area_q) ? (used_cur - area_q) : '0;

		ram_addr    = AB'(int'(pg) * REGIONS_PER_PAGE + int'(slot));
		vidx_s1     = AB'(int'(pg) * REGIONS_PER_PAGE + int'(slot_s1));
		commit_addr = AB'(int'(pg) * REGIONS_PER_PAGE + int'(free_slot_q));

		// candidate corner of the latched region, or the page origin
		rx_sw = SW'(rx_q);
		ry_sw = SW'(ry_q);
		cx    = cmd.origin ? '0 : (cmd.corner[1] ? rx_sw + SW'(rw_q) : rx_sw);
		cy    = cmd.origin ? '0 : (cmd.corner[0] ? ry_sw + SW'(rh_q) : ry_sw);
		bx_sw = SW'(best_x_q);
		by_sw = SW'(best_y_q);
		better_blocked = found_q && ((cy > by_sw) || ((cy == by_sw) && (cx >= bx_sw)));

		gx = SW'(rd_data[4*CB-1:3*CB]);
		gy = SW'(rd_data[3*CB-1:2*CB]);
		gw = SW'(rd_data[2*CB-1:CB]);
		gh = SW'(rd_data[CB-1:0]);
		x0 = SW'(cand_x_q);
		y0 = SW'(cand_y_q);
		x1 = x0 + w_sw;
		y1 = y0 + h_sw;
		overlap = (gx < x1) && (gx + gw > x0) && (gy < y1) && (gy + gh > y0);
		match   = (gx == SW'(ex_q)) && (gy == SW'(ey_q)) && (gw == w_sw) && (gh == h_sw);
		vs1     = valid_q[vidx_s1];

		wr_data = {best_x_q, best_y_q, wc, hc};

		sts.is_erase   = op_q;
		sts.layer_bad  = layer_bad;
		sts.size_ok    = (w_q != '0) && (h_q != '0) && (w_sw <= pw) && (h_sw <= ph);
		sts.page_open  = page < open_q;
		sts.lacks_area = free_a < area_q;
		sts.last_page  = ({1'b0, page} + (PCW+1)'(1)) == {1'b0, open_q};
		sts.can_open   = open_q < PCW'(MAX_PAGES);
		sts.slot_valid = valid_q[ram_addr];
		sts.cand_ok    = (cx + w_sw <= pw) && (cy + h_sw <= ph) && !better_blocked;
		sts.commit_ok  = found_q && free_found_q;
	end

	tara_ram #(
		.WIDTH(GW),
		.DEPTH(D)
	) u_geom (
		.clk  (clk),
		.we   (cmd.commit),
		.waddr(commit_addr),
		.wdata(wr_data),
		.re   (cmd.rd),
		.raddr(ram_addr),
		.rdata(rd_data)
	);

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q    <= op;
			w_q     <= rect_width;
			h_q     <= rect_height;
			layer_q <= erase_layer;
			ex_q    <= erase_x;
			ey_q    <= erase_y;
		end
		if (cmd.prep) begin
			area_q  <= wc * hc;
			total_q <= pwc * phc;
		end
		if (cmd.load_reg) begin
			rx_q <= rd_data[4*CB-1:3*CB];
			ry_q <= rd_data[3*CB-1:2*CB];
			rw_q <= rd_data[2*CB-1:CB];
			rh_q <= rd_data[CB-1:0];
		end
		if (cmd.take_cand) begin
			cand_x_q <= cx[CB-1:0];
			cand_y_q <= cy[CB-1:0];
		end
		if (cmd.eval && !hit_q) begin
			best_x_q <= cand_x_q;
			best_y_q <= cand_y_q;
		end
		if (cmd.note_free && !sts.slot_valid && !free_found_q) begin
			free_slot_q <= slot;
		end
		slot_s1 <= slot;
		if (cmd.load_out) begin
			status <= status_q;
			if (status_q == ST_OK && !op_q) begin
				placed_layer <= LAYER_W'(pg);
				placed_x     <= FIELD_W'(best_x_q);
				placed_y     <= FIELD_W'(best_y_q);
			end else begin
				placed_layer <= '0;
				placed_x     <= '0;
				placed_y     <= '0;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pw_cfg_q     <= PAGE_DIM_RESET;
			ph_cfg_q     <= PAGE_DIM_RESET;
			open_q       <= PCW'(1);
			used_q       <= '{default: '0};
			valid_q      <= '{default: 1'b0};
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			hit_q        <= 1'b0;
			chk_s1       <= 1'b0;
			status_q     <= ST_NO_ROOM;
		end else begin
			if (cfg.valid) begin
				if (cfg.index == REG_PAGE_WIDTH) begin
					pw_cfg_q <= cfg.data;
				end else if (cfg.index == REG_PAGE_HEIGHT) begin
					ph_cfg_q <= cfg.data;
				end
			end
			if (cmd.prep) begin
				status_q <= op_q ? (layer_bad ? ST_BAD_LAYER : ST_NOT_FOUND) : ST_NO_ROOM;
			end
			if (cmd.open_page) begin
				used_q[open_q[PB-1:0]] <= '0;
				open_q                 <= open_q + PCW'(1);
			end
			if (cmd.page_init) begin
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
			end
			if (cmd.note_free && !sts.slot_valid) begin
				free_found_q <= 1'b1;
			end
			if (cmd.take_cand) begin
				hit_q <= 1'b0;
			end
			chk_s1 <= cmd.scan;
			// read data of the previous scan beat is compared here
			if (chk_s1 && vs1) begin
				if (op_q) begin
					if (match && status_q == ST_NOT_FOUND) begin
						valid_q[vidx_s1] <= 1'b0;
						used_q[pg]       <= used_sub;
						status_q         <= ST_OK;
					end
				end else if (overlap) begin
					hit_q <= 1'b1;
				end
			end
			if (cmd.eval && !hit_q) begin
				found_q <= 1'b1;
			end
			if (cmd.commit) begin
				valid_q[commit_addr] <= 1'b1;
				used_q[pg]           <= used_cur + area_q;
				status_q             <= ST_OK;
			end
		end
	end
endmodule
`default_nettype wire

>>> src/texture_atlas_rect_allocator.sv
// Erase scans every region slot of its layer, or skips the scan on a bad layer; insert
// tries the open pages in turn, scanning all regions of a page for each candidate corner,
// bound by one geometry RAM read per overlap check. One request is in flight at a time.
// Reset: one page open, all used areas zero, all region valid bits clear at once.
// Geometry RAM contents are not cleared; no clearing pass.
`default_nettype none
module texture_atlas_rect_allocator #(
	parameter int MAX_PAGES        = 8,
	parameter int REGIONS_PER_PAGE = 16,
	parameter int COORD_BITS       = 13
) (
	input wire         clk,
	input wire         arst_n,
	tara_req_if.sink   req,
	tara_rsp_if.source rsp,
	tara_cfg_if.sink   cfg
);
	import tara_pkg::*;

	localparam int PCW = $clog2(MAX_PAGES + 1);
	localparam int SB  = (REGIONS_PER_PAGE > 1) ? $clog2(REGIONS_PER_PAGE) : 1;

	cmd_t           cmd;
	sts_t           sts;
	logic [PCW-1:0] page;
	logic [SB-1:0]  slot;
	logic           req_ready;
	logic           rsp_valid;

	assign req.ready = req_ready;
	assign rsp.valid = rsp_valid;

	tara_ctrl #(
		.MAX_PAGES       (MAX_PAGES),
		.REGIONS_PER_PAGE(REGIONS_PER_PAGE)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req_ready),
		.rsp_ready(rsp.ready),
		.rsp_valid(rsp_valid),
		.sts      (sts),
		.cmd      (cmd),
		.page     (page),
		.slot     (slot)
	);

	tara_dp #(
		.MAX_PAGES       (MAX_PAGES),
		.REGIONS_PER_PAGE(REGIONS_PER_PAGE),
		.COORD_BITS      (COORD_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.sts         (sts),
		.page        (page),
		.slot        (slot),
		.op          (req.op),
		.rect_width  (req.rect_width),
		.rect_height (req.rect_height),
		.erase_layer (req.erase_layer),
		.erase_x     (req.erase_x),
		.erase_y     (req.erase_y),
		.status      (rsp.status),
		.placed_layer(rsp.placed_layer),
		.placed_x    (rsp.placed_x),
		.placed_y    (rsp.placed_y)
	);
endmodule
`default_nettype wire

>>> src/tara_chk.sv
// Port-level checker for the allocator, bound to the top level.
// Depends on tara_pkg.
`default_nettype none
module tara_chk (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           req_valid,
	input wire                           req_ready,
	input wire                           rsp_valid,
	input wire                           rsp_ready,
	input wire [tara_pkg::STATUS_W-1:0]  status,
	input wire [tara_pkg::LAYER_W-1:0]   placed_layer,
	input wire [tara_pkg::FIELD_W-1:0]   placed_x,
	input wire [tara_pkg::FIELD_W-1:0]   placed_y
);
	import tara_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response beat dropped before taken");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(status) && $stable(placed_x) && $stable(placed_y))
		else $error("stalled response changed");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second request taken while one is in flight");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |->
			placed_layer == '0 && placed_x == '0 && placed_y == '0)
		else $error("placement fields set on a failed request");
endmodule

bind texture_atlas_rect_allocator tara_chk u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.status      (rsp.status),
	.placed_layer(rsp.placed_layer),
	.placed_x    (rsp.placed_x),
	.placed_y    (rsp.placed_y)
);
`default_nettype wire

>>> verif/texture_atlas_rect_allocator_chk.sv
// Checker for the texture atlas rectangle allocator: watches the request, response and
// config channels, predicts each response from its own page/region state and compares.
// Depends on tara_pkg and the tara_req_if, tara_rsp_if and tara_cfg_if interfaces.
`default_nettype none
module texture_atlas_rect_allocator_chk
	import tara_pkg::*;
#(
	parameter int MAX_PAGES        = 8,
	parameter int REGIONS_PER_PAGE = 16,
	parameter int COORD_BITS       = 13
) (
	input wire     clk,
	input wire     arst_n,
	tara_req_if    req,
	tara_rsp_if    rsp,
	tara_cfg_if    cfg,
	output int     fail_count,
	output int     awaiting,
	output int     placed_count
);

	localparam int unsigned DIM_CAP = 1 << (COORD_BITS - 1);
	localparam int SLOTS = MAX_PAGES * REGIONS_PER_PAGE;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [LAYER_W-1:0]  layer;
		logic [FIELD_W-1:0]  x;
		logic [FIELD_W-1:0]  y;
	} alloc_result_t;

	alloc_result_t expected_q[$];

	logic [FIELD_W-1:0] page_w, page_h;
	int unsigned        pages_open;
	int unsigned        area_used[MAX_PAGES];
	bit                 slot_used[SLOTS];
	int unsigned        rx[SLOTS], ry[SLOTS], rw[SLOTS], rh[SLOTS];
	int unsigned        best_x, best_y;
	bit                 have_best;

	function automatic bit collides(int unsigned page, int unsigned x0, int unsigned y0,
		int unsigned x1, int unsigned y1);
		int k;
		for (int s = 0; s < REGIONS_PER_PAGE; s++) begin
			k = page * REGIONS_PER_PAGE + s;
			if (slot_used[k] && rx[k] < x1 && rx[k] + rw[k] > x0 && ry[k] < y1 &&
				ry[k] + rh[k] > y0)
				return 1;
		end
		return 0;
	endfunction

	function automatic void try_spot(int unsigned page, int unsigned cx, int unsigned cy,
		int unsigned w, int unsigned h, int unsigned pw, int unsigned ph);
		if (cx + w > pw || cy + h > ph)
			return;
		if (have_best && (cy > best_y || (cy == best_y && cx >= best_x)))
			return;
		if (collides(page, cx, cy, cx + w, cy + h))
			return;
		have_best = 1;
		best_x = cx;
		best_y = cy;
	endfunction

	function automatic bit fit_on_page(int unsigned page, int unsigned w, int unsigned h,
		int unsigned pw, int unsigned ph);
		int slot;
		int k;
		slot = -1;
		for (int s = REGIONS_PER_PAGE - 1; s >= 0; s--)
			if (!slot_used[page * REGIONS_PER_PAGE + s])
				slot = s;
		if (slot < 0)
			return 0;
		have_best = 0;
		best_x = 0;
		best_y = 0;
		try_spot(page, 0, 0, w, h, pw, ph);
		for (int s = 0; s < REGIONS_PER_PAGE; s++) begin
			k = page * REGIONS_PER_PAGE + s;
			if (slot_used[k]) begin
				try_spot(page, rx[k], ry[k], w, h, pw, ph);
				try_spot(page, rx[k], ry[k] + rh[k], w, h, pw, ph);
				try_spot(page, rx[k] + rw[k], ry[k], w, h, pw, ph);
				try_spot(page, rx[k] + rw[k], ry[k] + rh[k], w, h, pw, ph);
			end
		end
		if (!have_best)
			return 0;
		k = page * REGIONS_PER_PAGE + slot;
		slot_used[k] = 1;
		rx[k] = best_x;
		ry[k] = best_y;
		rw[k] = w;
		rh[k] = h;
		area_used[page] += w * h;
		return 1;
	endfunction

	function automatic alloc_result_t allocate_or_free(logic is_erase, int unsigned w,
		int unsigned h, int unsigned layer, int unsigned ex, int unsigned ey);
		alloc_result_t r;
		int unsigned pw, ph, total, free_area, k;
		r = '0;
		r.status = ST_NO_ROOM;
		pw = (page_w > DIM_CAP) ? DIM_CAP : 32'(page_w);
		ph = (page_h > DIM_CAP) ? DIM_CAP : 32'(page_h);
		if (!is_erase) begin
			if (w != 0 && h != 0 && w <= pw && h <= ph) begin
				total = pw * ph;
				for (int unsigned p = 0; p < pages_open && p < MAX_PAGES; p++) begin
					free_area = (area_used[p] > total) ? 0 : total - area_used[p];
					if (free_area < w * h) begin
						if (p + 1 != pages_open)
							continue;
						if (pages_open < MAX_PAGES) begin
							area_used[pages_open] = 0;
							pages_open++;
						end
					end
					if (fit_on_page(p, w, h, pw, ph)) begin
						r.status = ST_OK;
						r.layer = LAYER_W'(p);
						r.x = FIELD_W'(best_x);
						r.y = FIELD_W'(best_y);
						break;
					end
				end
			end
		end else if (layer >= pages_open || layer >= MAX_PAGES) begin
			r.status = ST_BAD_LAYER;
		end else begin
			r.status = ST_NOT_FOUND;
			for (int s = 0; s < REGIONS_PER_PAGE; s++) begin
				k = layer * REGIONS_PER_PAGE + s;
				if (slot_used[k] && rx[k] == ex && ry[k] == ey && rw[k] == w && rh[k] == h) begin
					slot_used[k] = 0;
					area_used[layer] = (area_used[layer] > w * h) ? area_used[layer] - w * h : 0;
					r.status = ST_OK;
					break;
				end
			end
		end
		return r;
	endfunction

	assign awaiting = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t want;
		alloc_result_t got;
		if (!arst_n) begin
			page_w = PAGE_DIM_RESET;
			page_h = PAGE_DIM_RESET;
			pages_open = 1;
			foreach (area_used[i]) area_used[i] = 0;
			foreach (slot_used[i]) slot_used[i] = 0;
			expected_q.delete();
			fail_count <= 0;
			placed_count <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_PAGE_WIDTH)
					page_w = cfg.data;
				else if (cfg.index == REG_PAGE_HEIGHT)
					page_h = cfg.data;
			end
			if (req.valid && req.ready) begin
				want = allocate_or_free(req.op, 32'(req.rect_width), 32'(req.rect_height),
					32'(req.erase_layer), 32'(req.erase_x), 32'(req.erase_y));
				expected_q.insert(expected_q.size(), want);
			end
			if (rsp.valid && rsp.ready) begin
				got = {rsp.status, rsp.placed_layer, rsp.placed_x, rsp.placed_y};
				if (expected_q.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: response beat with nothing outstanding: %p", $realtime, got);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_q.pop_front();
					if (want != got) begin
						if (fail_count < 10)
							$display("%0t: mismatch exp st=%0d l=%0d x=%0d y=%0d got st=%0d l=%0d x=%0d y=%0d",
								$realtime, want.status, want.layer, want.x, want.y,
								got.status, got.layer, got.x, got.y);
						fail_count <= fail_count + 1;
					end else if (got.status == ST_OK) begin
						placed_count <= placed_count + 1;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> verif/texture_atlas_rect_allocator_tb.sv
// Testbench top for the texture atlas rectangle allocator: drives inserts, erases and page
// size writes with random gaps and stalls; the checker module predicts and compares.
// Depends on tara_pkg, the channel interfaces, the allocator and its checker.
`default_nettype none
module texture_atlas_rect_allocator_tb;
	import tara_pkg::*;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_ERASE  = 1'b1;

	logic clk = 0;
	logic arst_n = 0;
	int   fail_count, awaiting, placed_count;
	bit   steady;
	int   sent_items, sent_erases, page_settings;

	tara_req_if req ();
	tara_rsp_if rsp ();
	tara_cfg_if cfg ();

	texture_atlas_rect_allocator uut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg));

	texture_atlas_rect_allocator_chk chk (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.cfg(cfg), .fail_count(fail_count), .awaiting(awaiting), .placed_count(placed_count));

	always #2 clk = ~clk;

	initial begin
		#200_000_000;
		$display("timeout with %0d responses outstanding", awaiting);
		$display("FAILED: results differ");
		$finish;
	end

	// Regions known to be placed, kept so erases can hit real entries.
	typedef struct {
		logic [LAYER_W-1:0] layer;
		logic [FIELD_W-1:0] x, y, w, h;
	} region_t;
	region_t placed[$];
	logic [FIELD_W-1:0] inflight_w[$], inflight_h[$];
	logic inflight_op[$];

	function automatic int draw_gap();
		return steady ? 0 : $urandom_range(0, 7);
	endfunction

	// Response side: random stall per beat, records placements.
	initial begin
		int n;
		region_t got_r;
		rsp.ready = 0;
		@(posedge arst_n);
		forever begin
			n = draw_gap();
			if (n > 0) begin
				rsp.ready <= 0;
				repeat (n) @(posedge clk);
			end
			rsp.ready <= 1;
			do @(posedge clk); while (!rsp.valid);
			if (inflight_op.size() > 0) begin
				if (inflight_op[0] == OP_INSERT && rsp.status == ST_OK) begin
					got_r = '{rsp.placed_layer, rsp.placed_x, rsp.placed_y,
						inflight_w[0], inflight_h[0]};
					placed.insert(placed.size(), got_r);
				end
				void'(inflight_op.pop_front());
				void'(inflight_w.pop_front());
				void'(inflight_h.pop_front());
			end
		end
	end

	task automatic send_beat(logic op, logic [FIELD_W-1:0] w, logic [FIELD_W-1:0] h,
		logic [LAYER_W-1:0] layer, logic [FIELD_W-1:0] ex, logic [FIELD_W-1:0] ey);
		int n;
		n = draw_gap();
		if (n > 0) begin
			req.valid <= 0;
			repeat (n) @(posedge clk);
		end
		req.op <= op;
		req.rect_width <= w;
		req.rect_height <= h;
		req.erase_layer <= layer;
		req.erase_x <= ex;
		req.erase_y <= ey;
		req.valid <= 1;
		do @(posedge clk); while (!req.ready);
		inflight_op.insert(inflight_op.size(), op);
		inflight_w.insert(inflight_w.size(), w);
		inflight_h.insert(inflight_h.size(), h);
		sent_items++;
		if (op == OP_ERASE)
			sent_erases++;
	endtask

	task automatic insert(int w, int h);
		send_beat(OP_INSERT, FIELD_W'(w), FIELD_W'(h), LAYER_W'($urandom),
			FIELD_W'($urandom), FIELD_W'($urandom));
	endtask

	task automatic erase_known();
		int i;
		region_t r;
		if (placed.size() == 0) begin
			send_beat(OP_ERASE, FIELD_W'($urandom_range(1, 8)), FIELD_W'($urandom_range(1, 8)),
				'0, '0, '0);
			return;
		end
		i = $urandom_range(0, placed.size() - 1);
		r = placed[i];
		placed.delete(i);
		send_beat(OP_ERASE, r.w, r.h, r.layer, r.x, r.y);
	endtask

	// Only while idle: drop request valid, drain, then write the page width and height registers.
	task automatic set_page(logic [FIELD_W-1:0] w, logic [FIELD_W-1:0] h);
		req.valid <= 0;
		do @(posedge clk); while (awaiting != 0);
		repeat (30) @(posedge clk);
		placed.delete();
		cfg.index <= REG_PAGE_WIDTH;
		cfg.data <= w;
		cfg.valid <= 1;
		do @(posedge clk); while (!cfg.ready);
		cfg.index <= REG_PAGE_HEIGHT;
		cfg.data <= h;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 0;
		page_settings++;
	endtask

	task automatic random_phase(int count, int max_side);
		int pick;
		for (int i = 0; i < count; i++) begin
			steady = ($urandom_range(0, 9) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 55)
				insert($urandom_range(1, max_side), $urandom_range(1, max_side));
			else if (pick < 85)
				erase_known();
			else if (pick < 92)
				send_beat(OP_ERASE, FIELD_W'($urandom), FIELD_W'($urandom),
					LAYER_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
			else
				send_beat(1'($urandom), FIELD_W'($urandom), FIELD_W'($urandom),
					LAYER_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
		end
	endtask

	initial begin
		req.valid = 0;
		req.op = OP_INSERT;
		req.rect_width = 0;
		req.rect_height = 0;
		req.erase_layer = 0;
		req.erase_x = 0;
		req.erase_y = 0;
		cfg.valid = 0;
		cfg.index = REG_PAGE_WIDTH;
		cfg.data = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed, default 1024 x 1024 pages
		insert(0, 5);
		insert(5, 0);
		insert(1, 1);
		insert(1024, 1024);
		insert(1025, 1);
		insert(8191, 8191);
		send_beat(OP_ERASE, 1, 1, 7, 0, 0);
		send_beat(OP_ERASE, 1, 1, 0, 4096, 4096);
		send_beat(OP_ERASE, 1, 1, 0, 0, 0);
		send_beat(OP_ERASE, 1, 1, 0, 0, 0);
		send_beat(OP_ERASE, 1024, 1024, 1, 0, 0);
		// full region table on a page, then page limit
		set_page(8, 8);
		for (int i = 0; i < 18; i++)
			insert(1, 1);
		for (int i = 0; i < 9; i++)
			insert(8, 8);
		// shrunk page: used area now exceeds the smaller page
		set_page(4, 4);
		insert(1, 1);
		send_beat(OP_ERASE, 8, 8, 3, 0, 0);
		set_page(4096, 1);
		insert(4096, 1);
		insert(1, 2);
		set_page(8191, 0);
		insert(1, 1);
		set_page(1, 4096);
		insert(1, 4096);
		insert(1, 4097);

		// random
		set_page(40, 40);
		random_phase(180, 20);
		set_page(24, 16);
		random_phase(120, 12);
		set_page(100, 60);
		random_phase(120, 50);
		set_page(1024, 1024);
		random_phase(60, 1024);

		req.valid <= 0;
		do @(posedge clk); while (awaiting != 0);
		repeat (50) @(posedge clk);
		$display("covered %0d requests (%0d erases) over %0d page size settings",
			sent_items, sent_erases, page_settings + 1);
		$display("%0d successful placements and removals checked", placed_count);
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
`default_nettype wire
